// File: sv/rlt_pkg.sv
// Shared types, codes and helpers for the receipt ledger TTL table.
package rlt_pkg;

	localparam int TableDepth = 16;
	localparam int KeyBytes   = 32;
	localparam int LinkBytes  = 16;

	localparam logic [2:0] OpInsert = 3'd0;
	localparam logic [2:0] OpLookup = 3'd1;
	localparam logic [2:0] OpRemove = 3'd2;
	localparam logic [2:0] OpCull   = 3'd3;
	localparam logic [2:0] OpClear  = 3'd4;

	localparam logic [2:0] CmdInsert = 3'd0;
	localparam logic [2:0] CmdLookup = 3'd1;
	localparam logic [2:0] CmdRemove = 3'd2;
	localparam logic [2:0] CmdCull   = 3'd3;
	localparam logic [2:0] CmdClear  = 3'd4;
	localparam logic [2:0] CmdIgnore = 3'd5;
	localparam logic [2:0] CmdNop    = 3'd6;

	localparam logic [1:0] StatusDone    = 2'd0;
	localparam logic [1:0] StatusIgnored = 2'd1;
	localparam logic [1:0] StatusFull    = 2'd2;

	localparam logic [1:0] KindDirect      = 2'd0;
	localparam logic [1:0] KindLinkPacket  = 2'd1;
	localparam logic [1:0] KindLinkRes     = 2'd2;
	localparam logic [1:0] KindPropagation = 2'd3;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [1:0]       kind;
		logic [3:0][63:0] key;
		logic [1:0][63:0] link;
		logic [31:0]      msg;
		logic [31:0]      now;
		logic [31:0]      created;
	} req_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [3:0][63:0] key;
		logic [1:0][63:0] link;
		logic [31:0]      msg;
		logic [31:0]      created;
	} entry_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [1:0]  kind;
		logic [31:0] msg;
		logic [31:0] created;
	} result_t;

	// byte 0 is the top byte of word 0
	function automatic logic [63:0] byte_mask(input int nbytes, input int w);
		int r;
		r = nbytes - 8 * w;
		if (r >= 8) return {64{1'b1}};
		else if (r <= 0) return 64'd0;
		else return {64{1'b1}} << (64 - 8 * r);
	endfunction

endpackage

// File: sv/rlt_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module rlt_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [4:0]         in_user,
	input  logic [447:0]       in_data,
	output logic               q_valid,
	output rlt_pkg::req_t      q_req,
	input  logic               q_pop
);
	rlt_pkg::req_t slot_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    fill_q;
	rlt_pkg::req_t cls;
	logic [2:0]    op;
	logic          push;
	logic          pop;

	assign op = in_user[2:0];

	always_comb begin
		cls.kind    = in_user[4:3];
		cls.key     = in_data[255:0];
		cls.link    = (cls.kind == rlt_pkg::KindLinkPacket || cls.kind == rlt_pkg::KindLinkRes)
			? in_data[383:256] : 128'd0;
		cls.msg     = in_data[415:384];
		cls.now     = in_data[447:416];
		cls.created = (cls.now == 32'd0) ? 32'd1 : cls.now;
		unique case (op)
			rlt_pkg::OpInsert: cls.cmd = (cls.msg == 32'd0) ? rlt_pkg::CmdIgnore
				: rlt_pkg::CmdInsert;
			rlt_pkg::OpLookup: cls.cmd = rlt_pkg::CmdLookup;
			rlt_pkg::OpRemove: cls.cmd = rlt_pkg::CmdRemove;
			rlt_pkg::OpCull:   cls.cmd = rlt_pkg::CmdCull;
			rlt_pkg::OpClear:  cls.cmd = rlt_pkg::CmdClear;
			default:           cls.cmd = rlt_pkg::CmdNop;
		endcase
	end

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_req    = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: sv/rlt_back.sv
// Back end: scans and compacts the receipt table one entry per cycle.
module rlt_back #(
	parameter int TABLE_DEPTH = rlt_pkg::TableDepth,
	parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  rlt_pkg::req_t        q_req,
	output logic                 q_pop,
	input  logic [3:0][4:0]      limit,
	input  logic [3:0][31:0]     ttl,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rlt_pkg::result_t     out_res,
	output logic [CW-1:0]        out_total
);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int LW = ((CW > 5) ? CW : 5) + 1;

	localparam logic [1:0] StIdle   = 2'd0;
	localparam logic [1:0] StScanA  = 2'd1;
	localparam logic [1:0] StScanB  = 2'd2;
	localparam logic [1:0] StFinish = 2'd3;

	rlt_pkg::entry_t  ent_q [TABLE_DEPTH];
	rlt_pkg::req_t    req_q;
	logic [1:0]       state_q;
	logic [CW-1:0]    rd_q, wr_q, count_q, kcnt_q, excess_q;
	logic             found_q;
	logic [1:0]       fkind_q;
	logic [31:0]      fmsg_q, fcre_q;
	logic             out_valid_q;
	rlt_pkg::result_t out_res_q;
	logic [CW-1:0]    out_total_q;

	rlt_pkg::entry_t  cur;
	rlt_pkg::entry_t  new_ent;
	logic             match, cull_hit, drop_a, at_end, same_kind;
	logic [31:0]      age;
	logic [LW-1:0]    need, lim_ext;
	logic             trim_cmd, out_free, full;
	logic [1:0]       pre0_kind;
	logic [63:0]      pre0, pre1;
	logic [1:0]       fin_status;
	logic [CW-1:0]    fin_count;

	assign cur       = ent_q[rd_q[IW-1:0]];
	assign at_end    = (rd_q == count_q);
	assign same_kind = (cur.kind == req_q.kind);

	always_comb begin
		logic keq, leq;
		keq = 1'b1;
		leq = 1'b1;
		pre0_kind = cur.kind;
		pre0 = (pre0_kind == rlt_pkg::KindDirect) ? cur.key[0] : 64'd0;
		pre1 = (pre0_kind == rlt_pkg::KindDirect) ? cur.key[1] : 64'd0;
		for (int w = 0; w < 4; w++)
			if (((cur.key[w] ^ req_q.key[w]) & rlt_pkg::byte_mask(rlt_pkg::KeyBytes, w)) != 0)
				keq = 1'b0;
		for (int w = 0; w < 2; w++)
			if (((cur.link[w] ^ req_q.link[w]) & rlt_pkg::byte_mask(rlt_pkg::LinkBytes, w)) != 0)
				leq = 1'b0;
		if (req_q.kind == rlt_pkg::KindDirect)
			match = (pre0 == req_q.key[0]) && (pre1 == req_q.key[1]);
		else
			match = same_kind && keq && (req_q.kind == rlt_pkg::KindPropagation || leq);
	end

	assign age      = req_q.now - cur.created;
	assign cull_hit = same_kind && (ttl[req_q.kind] != 32'd0) && (cur.created != 32'd0)
		&& (age > ttl[req_q.kind]);
	assign drop_a   = (req_q.cmd == rlt_pkg::CmdCull) ? cull_hit
		: (req_q.cmd == rlt_pkg::CmdInsert || req_q.cmd == rlt_pkg::CmdRemove) && match;

	assign trim_cmd = (req_q.cmd == rlt_pkg::CmdInsert || req_q.cmd == rlt_pkg::CmdCull);
	assign lim_ext  = LW'(limit[req_q.kind]);
	assign need     = LW'(kcnt_q) + LW'(req_q.cmd == rlt_pkg::CmdInsert);
	assign out_free = !out_valid_q || out_ready;
	assign full     = (count_q >= CW'(TABLE_DEPTH));

	always_comb begin
		new_ent.kind    = req_q.kind;
		new_ent.key     = req_q.key;
		new_ent.link    = req_q.link;
		new_ent.msg     = req_q.msg;
		new_ent.created = req_q.created;
	end

	always_comb begin
		fin_status = rlt_pkg::StatusDone;
		fin_count  = count_q;
		unique case (req_q.cmd)
			rlt_pkg::CmdIgnore: fin_status = rlt_pkg::StatusIgnored;
			rlt_pkg::CmdInsert: begin
				if (full) fin_status = rlt_pkg::StatusFull;
				else fin_count = count_q + 1'b1;
			end
			rlt_pkg::CmdClear: fin_count = '0;
			default: ;
		endcase
	end

	assign q_pop     = (state_q == StIdle) && q_valid;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;
	assign out_total = out_total_q;

	always_ff @(posedge clk) begin
		if ((state_q == StScanA && !at_end && !drop_a) ||
		    (state_q == StScanB && !at_end && !(same_kind && excess_q != '0)))
			ent_q[wr_q[IW-1:0]] <= cur;
		else if (state_q == StFinish && out_free && req_q.cmd == rlt_pkg::CmdInsert && !full)
			ent_q[count_q[IW-1:0]] <= new_ent;
	end

	always_ff @(posedge clk) begin
		if (q_pop) req_q <= q_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			rd_q        <= '0;
			wr_q        <= '0;
			count_q     <= '0;
			kcnt_q      <= '0;
			excess_q    <= '0;
			found_q     <= 1'b0;
			fkind_q     <= 2'd0;
			fmsg_q      <= 32'd0;
			fcre_q      <= 32'd0;
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
			out_total_q <= '0;
		end else begin
			if (state_q == StFinish && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (q_valid) begin
						rd_q    <= '0;
						wr_q    <= '0;
						kcnt_q  <= '0;
						found_q <= 1'b0;
						fkind_q <= 2'd0;
						fmsg_q  <= 32'd0;
						fcre_q  <= 32'd0;
						if (q_req.cmd == rlt_pkg::CmdInsert || q_req.cmd == rlt_pkg::CmdLookup ||
						    q_req.cmd == rlt_pkg::CmdRemove || q_req.cmd == rlt_pkg::CmdCull)
							state_q <= StScanA;
						else
							state_q <= StFinish;
					end
				end
				StScanA: begin
					if (at_end) begin
						count_q <= wr_q;
						rd_q    <= '0;
						wr_q    <= '0;
						if (trim_cmd && lim_ext != '0 && need > lim_ext) begin
							excess_q <= CW'(need - lim_ext);
							state_q  <= StScanB;
						end else begin
							state_q <= StFinish;
						end
					end else begin
						rd_q <= rd_q + 1'b1;
						if (!drop_a) begin
							wr_q <= wr_q + 1'b1;
							if (same_kind) kcnt_q <= kcnt_q + 1'b1;
						end
						if (req_q.cmd == rlt_pkg::CmdLookup && match && !found_q) begin
							found_q <= 1'b1;
							fkind_q <= cur.kind;
							fmsg_q  <= cur.msg;
							fcre_q  <= cur.created;
						end
					end
				end
				StScanB: begin
					if (at_end) begin
						count_q <= wr_q;
						state_q <= StFinish;
					end else begin
						rd_q <= rd_q + 1'b1;
						if (same_kind && excess_q != '0) excess_q <= excess_q - 1'b1;
						else wr_q <= wr_q + 1'b1;
					end
				end
				StFinish: begin
					if (out_free) begin
						out_res_q.found   <= found_q;
						out_res_q.kind    <= fkind_q;
						out_res_q.msg     <= fmsg_q;
						out_res_q.created <= fcre_q;
						out_res_q.status  <= fin_status;
						count_q           <= fin_count;
						out_total_q       <= fin_count;
						state_q           <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

endmodule

// File: sv/receipt_ledger_ttl_table.sv
// Top level of the receipt ledger TTL table: config registers, front end and back end.
// Lookup and remove make one pass over the entries held; insert and cull make a
// second pass to trim a kind over its limit; clear, ignored and unknown skip the scan.
// Throughput: one request at a time in the back end, which walks the table one
// entry per cycle; a two-entry queue takes new requests meanwhile.
// Reset clears entry count, limits, TTLs and the queue; entry contents are not reset.
module receipt_ledger_ttl_table #(
	parameter int TABLE_DEPTH = rlt_pkg::TableDepth,
	localparam int CW    = $clog2(TABLE_DEPTH + 1),
	localparam int OUT_W = ((64 + CW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [4:0]       s_tuser,  // op[2:0], kind[4:3]
	input  logic [447:0]     s_tdata,  // key_word0..3, link_word0..1, message_ident, time_now
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [4:0]       m_tuser,  // status[1:0], found[2], found_kind[4:3]
	output logic [OUT_W-1:0] m_tdata,  // found_message, found_created, entry_total, zero pad
	input  logic             cfg_we,
	input  logic [2:0]       cfg_addr,
	input  logic [31:0]      cfg_wdata
);
	logic [3:0][4:0]   limit_q;
	logic [3:0][31:0]  ttl_q;
	logic              q_valid, q_pop;
	rlt_pkg::req_t     q_req;
	rlt_pkg::result_t  res;
	logic [CW-1:0]     total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
			ttl_q   <= '0;
		end else if (cfg_we) begin
			if (cfg_addr[2]) ttl_q[cfg_addr[1:0]] <= cfg_wdata;
			else limit_q[cfg_addr[1:0]] <= cfg_wdata[4:0];
		end
	end

	rlt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_user  (s_tuser),
		.in_data  (s_tdata),
		.q_valid  (q_valid),
		.q_req    (q_req),
		.q_pop    (q_pop)
	);

	rlt_back #(.TABLE_DEPTH(TABLE_DEPTH), .CW(CW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_req     (q_req),
		.q_pop     (q_pop),
		.limit     (limit_q),
		.ttl       (ttl_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res),
		.out_total (total)
	);

	assign m_tuser = {res.kind, res.found, res.status};
	assign m_tdata = OUT_W'({total, res.created, res.msg});

endmodule

// File: sv/rlt_checker.sv
// Port-level checks for the receipt ledger TTL table, bound to the top level.
module rlt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [4:0]  m_tuser,
	input logic [63:0] m_low
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[1:0] != 2'd3)
		else $error("undefined status code");

	a_nofind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] != 2'd0 |-> !m_tuser[2])
		else $error("found set on a non-done status");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[2] |-> m_tuser[4:3] == 2'd0 && m_low == 64'd0)
		else $error("found fields set without a hit");

endmodule

bind receipt_ledger_ttl_table rlt_checker u_rlt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser),
	.m_low    (m_tdata[63:0])
);
